### rtl/core/biquad_lowpass_filter_macros.svh
// Assertion macros for the biquad lowpass filter checker.
// Depends on nothing; included by the checker file.
`ifndef BIQUAD_LOWPASS_FILTER_MACROS_SVH
`define BIQUAD_LOWPASS_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bqlpf_pkg.sv
// Shared types and constants of the biquad lowpass filter.
// Depends on nothing; used by every module of the block.
package bqlpf_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COEF_WIDTH   = 32;
	localparam int DEF_STATE_WIDTH  = 48;
	localparam int STATE_FRAC       = 16;
	localparam int COEF_INT_BITS    = 4;
	localparam int DEF_OPND_WIDTH   = (DEF_STATE_WIDTH + 2) - (DEF_STATE_WIDTH + 2) / 2 + 1;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_B0     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_A1     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_A2     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FB,
		ST_FB_DRAIN,
		ST_ROUND,
		ST_SUM,
		ST_FF,
		ST_FF_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic vld;
		logic hi;
		logic neg;
	} mul_ctl_t;

endpackage

### rtl/core/bqlpf_mul.sv
// Shared signed multiplier with one product register.
// Depends on bqlpf_pkg for the control struct.
module bqlpf_mul #(
	parameter int COEF_WIDTH = bqlpf_pkg::DEF_COEF_WIDTH,
	parameter int OPND_WIDTH = bqlpf_pkg::DEF_OPND_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic signed [COEF_WIDTH-1:0]             coef,
	input  logic signed [OPND_WIDTH-1:0]             opnd,
	input  bqlpf_pkg::mul_ctl_t                      ctl,
	output logic signed [COEF_WIDTH+OPND_WIDTH-1:0]  prod_s1,
	output bqlpf_pkg::mul_ctl_t                      ctl_s1
);
	import bqlpf_pkg::*;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * opnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

endmodule

### rtl/core/biquad_lowpass_filter.sv
// Top level of the second-order lowpass biquad, direct form II, fixed point.
// Depends on bqlpf_pkg and bqlpf_mul.
//
// channel   direction  fields (lowest bit up)
// s_axis    in         tdata: sample_in
// m_axis    out        tdata: filtered_out; tuser: guard_hit
// cfg       in         cfg_addr selects filter_enable, forward_gain, a1, a2
//
// A filtered word passes the feedback, round, sum and feed-forward steps before
// its result; the one shared multiplier forms six partial products, one per cycle.
// A word that passes through with filtering off goes straight to the output step.
// A new word is accepted only once the last result has been loaded for output.
// Reset clears the delays, the configuration and the control registers; no clearing pass.
// A result waiting on m_axis_tready holds the sequencer in its last step.
module biquad_lowpass_filter #(
	parameter int SAMPLE_WIDTH = bqlpf_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = bqlpf_pkg::DEF_COEF_WIDTH,
	parameter int STATE_WIDTH  = bqlpf_pkg::DEF_STATE_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample_in
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // filtered_out
	output logic                                   m_axis_tuser,  // guard_hit
	input  logic                                   cfg_we,
	input  logic [bqlpf_pkg::REG_IDX_W-1:0]        cfg_addr,
	input  logic [COEF_WIDTH-1:0]                  cfg_wdata
);
	import bqlpf_pkg::*;

	localparam int TD_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int SUM_W     = STATE_WIDTH + 2;
	localparam int LO_W      = SUM_W / 2;
	localparam int MUL_W     = SUM_W - LO_W + 1;
	localparam int PROD_W    = COEF_WIDTH + MUL_W;
	localparam int COEF_FRAC = COEF_WIDTH - COEF_INT_BITS;
	localparam int Y_SHIFT   = COEF_FRAC + STATE_FRAC;
	localparam int ACC_A     = COEF_WIDTH + STATE_WIDTH + 3;
	localparam int ACC_B     = SAMPLE_WIDTH + COEF_WIDTH + 13;
	localparam int ACC_W     = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam logic [1:0] FB_LAST = 2'd3;
	localparam logic [1:0] FF_LAST = 2'd1;
	localparam logic signed [ACC_W-1:0] W0_HALF = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] Y_HALF  = ACC_W'(1) << (Y_SHIFT - 1);

	state_t state_q, state_d;
	logic [1:0] step_q;

	logic                            enable_q;
	logic signed [COEF_WIDTH-1:0]    b0_q, a1_q, a2_q;
	logic signed [SAMPLE_WIDTH-1:0]  x_q;
	logic                            bypass_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [STATE_WIDTH-1:0]   w0_q, w1_q, w2_q;
	logic signed [SUM_W-1:0]         s_q;
	logic                            guard_q;
	logic [SAMPLE_WIDTH-1:0]         out_data_q;
	logic                            out_guard_q;
	logic                            out_valid_q;

	logic                            in_acc;
	logic                            can_load;
	logic signed [SAMPLE_WIDTH-1:0]  x_in;
	logic signed [ACC_W-1:0]         x_in_ext, x_q_ext;
	logic signed [ACC_W-1:0]         prod_ext, term;
	logic signed [ACC_W-1:0]         w0_sum, w0_rnd, xs;
	logic [ACC_W-STATE_WIDTH:0]      w0_top, xs_top;
	logic                            w0_fit, xs_fit;
	logic signed [STATE_WIDTH-1:0]   xs_sat, w0_new;
	logic signed [SUM_W-1:0]         w0_sx, w1_sx, w2_sx, s_new, src;
	logic signed [ACC_W-1:0]         y_sum, y_rnd;
	logic [ACC_W-SAMPLE_WIDTH:0]     y_top;
	logic signed [SAMPLE_WIDTH-1:0]  y_sat;

	mul_ctl_t                        mul_ctl, ctl_s1;
	logic signed [COEF_WIDTH-1:0]    mul_coef;
	logic signed [MUL_W-1:0]         mul_opnd;
	logic signed [PROD_W-1:0]        prod_s1;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign can_load      = !out_valid_q || m_axis_tready;
	assign x_in          = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign x_in_ext      = {{(ACC_W-SAMPLE_WIDTH){x_in[SAMPLE_WIDTH-1]}}, x_in};
	assign x_q_ext       = {{(ACC_W-SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			b0_q     <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_B0:     b0_q     <= cfg_wdata;
				REG_A1:     a1_q     <= cfg_wdata;
				REG_A2:     a2_q     <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_acc) state_d = enable_q ? ST_FB : ST_OUT;
			ST_FB:       if (step_q == FB_LAST) state_d = ST_FB_DRAIN;
			ST_FB_DRAIN: state_d = ST_ROUND;
			ST_ROUND:    state_d = ST_SUM;
			ST_SUM:      state_d = ST_FF;
			ST_FF:       if (step_q == FF_LAST) state_d = ST_FF_DRAIN;
			ST_FF_DRAIN: state_d = ST_OUT;
			ST_OUT:      if (can_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier request and operands
	always_comb begin
		mul_ctl  = '0;
		mul_coef = b0_q;
		src      = s_q;
		case (state_q)
			ST_FB: begin
				mul_ctl.vld = 1'b1;
				mul_ctl.hi  = step_q[0];
				mul_ctl.neg = 1'b1;
				mul_coef    = step_q[1] ? a2_q : a1_q;
				src         = step_q[1] ? w2_sx : w1_sx;
			end
			ST_FF: begin
				mul_ctl.vld = 1'b1;
				mul_ctl.hi  = step_q[0];
				mul_ctl.neg = 1'b0;
				mul_coef    = b0_q;
				src         = s_q;
			end
			default: ;
		endcase
		mul_opnd = mul_ctl.hi ? {src[SUM_W-1], src[SUM_W-1:LO_W]}
		                      : {{(MUL_W-LO_W){1'b0}}, src[LO_W-1:0]};
	end

	bqlpf_mul #(
		.COEF_WIDTH (COEF_WIDTH),
		.OPND_WIDTH (MUL_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (mul_coef),
		.opnd    (mul_opnd),
		.ctl     (mul_ctl),
		.prod_s1 (prod_s1),
		.ctl_s1  (ctl_s1)
	);

	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign term     = ctl_s1.hi ? (prod_ext <<< LO_W) : prod_ext;

	// intermediate: round, range check, replace with the sample on overflow
	assign w0_sum = acc_q + W0_HALF;
	assign w0_rnd = w0_sum >>> COEF_FRAC;
	assign w0_top = w0_rnd[ACC_W-1:STATE_WIDTH-1];
	assign w0_fit = (&w0_top) | ~(|w0_top);
	assign xs     = x_q_ext <<< STATE_FRAC;
	assign xs_top = xs[ACC_W-1:STATE_WIDTH-1];
	assign xs_fit = (&xs_top) | ~(|xs_top);
	assign xs_sat = xs_fit ? xs[STATE_WIDTH-1:0]
	              : (xs[ACC_W-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
	                             : {1'b0, {(STATE_WIDTH-1){1'b1}}});
	assign w0_new = w0_fit ? w0_rnd[STATE_WIDTH-1:0] : xs_sat;

	assign w0_sx = {{2{w0_q[STATE_WIDTH-1]}}, w0_q};
	assign w1_sx = {{2{w1_q[STATE_WIDTH-1]}}, w1_q};
	assign w2_sx = {{2{w2_q[STATE_WIDTH-1]}}, w2_q};
	assign s_new = w0_sx + (w1_sx <<< 1) + w2_sx;

	// output: round and saturate
	assign y_sum = acc_q + Y_HALF;
	assign y_rnd = y_sum >>> Y_SHIFT;
	assign y_top = y_rnd[ACC_W-1:SAMPLE_WIDTH-1];
	assign y_sat = ((&y_top) | ~(|y_top)) ? y_rnd[SAMPLE_WIDTH-1:0]
	             : (y_rnd[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
	                               : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			bypass_q    <= 1'b0;
			w1_q        <= '0;
			w2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_FB || state_q == ST_FF) && state_d == state_q) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
			if (in_acc) begin
				bypass_q <= !enable_q;
			end
			if (state_q == ST_SUM) begin
				w2_q <= w1_q;
				w1_q <= w0_q;
			end
			if (state_q == ST_OUT && can_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q   <= x_in;
			acc_q <= x_in_ext <<< (STATE_FRAC + COEF_FRAC);
		end else if (ctl_s1.vld) begin
			acc_q <= ctl_s1.neg ? (acc_q - term) : (acc_q + term);
		end else if (state_q == ST_SUM) begin
			acc_q <= '0;
		end
		if (state_q == ST_ROUND) begin
			w0_q    <= w0_new;
			guard_q <= !w0_fit;
		end
		if (state_q == ST_SUM) begin
			s_q <= s_new;
		end
		if (state_q == ST_OUT && can_load) begin
			out_data_q  <= bypass_q ? x_q : y_sat;
			out_guard_q <= bypass_q ? 1'b0 : guard_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TD_W-SAMPLE_WIDTH){1'b0}}, out_data_q};
	assign m_axis_tuser  = out_guard_q;

endmodule

### rtl/core/bqlpf_chk.sv
// Port-level checker for the biquad lowpass filter, bound to the top level.
// Depends on bqlpf_pkg and biquad_lowpass_filter_macros.svh.
`include "biquad_lowpass_filter_macros.svh"

module bqlpf_chk #(
	parameter int SAMPLE_WIDTH = bqlpf_pkg::DEF_SAMPLE_WIDTH
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
	input logic                               m_axis_tuser
);
	import bqlpf_pkg::*;

	logic in_word, out_stall;

	assign in_word   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`BQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_word, !s_axis_tready, "ready after accept")
	`BQ_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without work")
	`BQ_ASSERT_NEXT(a_valid_held, clk, arst_n, out_stall, m_axis_tvalid, "result dropped")
	`BQ_ASSERT_NEXT(a_payload_held, clk, arst_n, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled word changed")

endmodule

bind biquad_lowpass_filter bqlpf_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqlpf_chk (.*);

### tb/testbench.sv
// Self-checking bench for biquad_lowpass_filter: streams samples through the
// block and checks each filtered word against a bit-exact fixed-point model.
// Depends on bqlpf_pkg and the biquad_lowpass_filter RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW         = bqlpf_pkg::DEF_SAMPLE_WIDTH;
	localparam int CW         = bqlpf_pkg::DEF_COEF_WIDTH;
	localparam int DW         = bqlpf_pkg::DEF_STATE_WIDTH;
	localparam int DFRAC      = bqlpf_pkg::STATE_FRAC;
	localparam int CFRAC      = CW - bqlpf_pkg::COEF_INT_BITS;
	localparam int SETTLE     = 24;
	localparam int HOLD_AT    = 520;
	localparam int HOLD_LEN   = 500;
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 105;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [SW-1:0] filtered;
		logic          guard;
	} filter_word_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [15:0]   s_axis_tdata = '0;   // sample_in
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [15:0]   m_axis_tdata;        // filtered_out
	logic          m_axis_tuser;        // guard_hit
	logic          cfg_we = 1'b0;
	logic [bqlpf_pkg::REG_IDX_W-1:0] cfg_addr = '0;
	logic [CW-1:0] cfg_wdata = '0;

	logic                 lp_enable = 1'b0;
	logic signed [CW-1:0] lp_b0 = '0;
	logic signed [CW-1:0] lp_a1 = '0;
	logic signed [CW-1:0] lp_a2 = '0;
	logic signed [DW-1:0] lp_w1 = '0;
	logic signed [DW-1:0] lp_w2 = '0;

	logic [SW-1:0] sample_q [$];
	filter_word_t  filtered_q [$];
	filter_word_t  want;
	int            words_queued = 0;
	int            words_sent = 0;
	int            words_checked = 0;
	int            mismatches = 0;
	int            cycle_count = 0;
	int            hold_left = 0;
	logic          hold_done = 1'b0;
	logic          calm = 1'b0;
	logic [SW-1:0] last_sample = '0;

	logic [31:0] preset_b0 [3] = '{32'd18107427, 32'd78621063, 32'd972300};
	logic [31:0] preset_a1 [3] = '{-32'sd306816357, 32'd0, -32'sd489277305};
	logic [31:0] preset_a2 [3] = '{32'd110810693, 32'd46056130, 32'd224734164};
	logic [31:0] corner_coef [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
		32'h1000_0000, 32'hF000_0000};

	biquad_lowpass_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic filter_word_t lowpass_step(input logic [SW-1:0] raw);
		logic signed [127:0] xw, a1w, a2w, b0w, w1w, w2w, w0w, acc, w0_full, y_full;
		logic signed [DW-1:0] w0;
		filter_word_t res;
		xw  = $signed(raw);
		res.guard = 1'b0;
		if (!lp_enable) begin
			res.filtered = raw;
			return res;
		end
		a1w = lp_a1;
		a2w = lp_a2;
		b0w = lp_b0;
		w1w = lp_w1;
		w2w = lp_w2;
		acc = (xw <<< (DFRAC + CFRAC)) - a1w * w1w - a2w * w2w;
		w0_full = (acc + (128'sd1 <<< (CFRAC - 1))) >>> CFRAC;
		if (w0_full >= -(128'sd1 <<< (DW - 1)) && w0_full < (128'sd1 <<< (DW - 1))) begin
			w0 = w0_full[DW-1:0];
		end else begin
			w0 = DW'(xw <<< DFRAC);
			res.guard = 1'b1;
		end
		w0w = w0;
		y_full = b0w * w0w + ((b0w * w1w) <<< 1) + b0w * w2w;
		y_full = (y_full + (128'sd1 <<< (CFRAC + DFRAC - 1))) >>> (CFRAC + DFRAC);
		if (y_full > 128'sd32767)
			res.filtered = 16'h7FFF;
		else if (y_full < -128'sd32768)
			res.filtered = 16'h8000;
		else
			res.filtered = y_full[SW-1:0];
		lp_w2 = lp_w1;
		lp_w1 = w0;
		return res;
	endfunction

	function automatic logic [SW-1:0] next_sample();
		logic [SW-1:0] s;
		case ($urandom_range(9))
			0: s = 16'h7FFF;
			1: s = 16'h8000;
			2: s = $urandom_range(2) == 0 ? 16'h0000 : ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
			3, 4: s = last_sample;
			5: s = 16'($signed($urandom_range(510)) - 255);
			default: s = SW'($urandom());
		endcase
		last_sample = s;
		return s;
	endfunction

	task automatic write_reg(input logic [bqlpf_pkg::REG_IDX_W-1:0] idx,
			input logic [CW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			bqlpf_pkg::REG_ENABLE: lp_enable = val[0];
			bqlpf_pkg::REG_B0:     lp_b0 = val;
			bqlpf_pkg::REG_A1:     lp_a1 = val;
			bqlpf_pkg::REG_A2:     lp_a2 = val;
			default: ;
		endcase
	endtask

	task automatic program_filter(input logic [CW-1:0] en_word, input logic [CW-1:0] b0,
			input logic [CW-1:0] a1, input logic [CW-1:0] a2);
		write_reg(bqlpf_pkg::REG_ENABLE, en_word);
		write_reg(bqlpf_pkg::REG_B0, b0);
		write_reg(bqlpf_pkg::REG_A1, a1);
		write_reg(bqlpf_pkg::REG_A2, a2);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_sample(input logic [SW-1:0] s);
		sample_q.push_back(s);
		words_queued++;
	endtask

	task automatic settle();
		while (words_checked != words_queued)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				filtered_q.push_back(lowpass_step(s_axis_tdata));
				words_sent <= words_sent + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
					s_axis_tdata  <= sample_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && words_sent >= HOLD_AT) begin
				hold_done     <= 1'b1;
				hold_left     <= HOLD_LEN;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 35);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_checked++;
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: filtered_out=%0d guard_hit=%0b",
						$signed(m_axis_tdata), m_axis_tuser);
			end else begin
				want = filtered_q.pop_front();
				if (m_axis_tdata !== want.filtered || m_axis_tuser !== want.guard) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: expected %0d/%0b, got %0d/%0b", words_checked,
							$signed(want.filtered), want.guard,
							$signed(m_axis_tdata), m_axis_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("biquad_lowpass_filter regression: fail");
			$finish;
		end
	end

	initial begin
		logic [CW-1:0] en_word, b0, a1, a2;
		int            mode, p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// pass-through out of reset
		queue_sample(16'h7FFF);
		queue_sample(16'h8000);
		queue_sample(16'h0000);
		queue_sample(16'h0001);
		queue_sample(16'hFFFF);
		settle();

		// stable lowpass: steps between extremes
		program_filter(32'h0000_0001, preset_b0[0], preset_a1[0], preset_a2[0]);
		repeat (3) queue_sample(16'h7FFF);
		repeat (3) queue_sample(16'h8000);
		queue_sample(16'h0000);
		queue_sample(16'd12345);
		settle();

		// runaway feedback: intermediate overflow and output saturation
		program_filter(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		repeat (8) queue_sample(16'h7FFF);
		settle();

		// disable keeps the delays, then resume
		program_filter(32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_sample(16'h8000);
		queue_sample(16'h0007);
		settle();
		program_filter(32'hA5A5_A5A5, preset_b0[2], preset_a1[2], preset_a2[2]);
		queue_sample(16'h8000);
		queue_sample(16'h7FFF);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			mode = ph % 4;
			p = $urandom_range(2);
			en_word = $urandom();
			en_word[0] = ($urandom_range(99) < 85);
			case (mode)
				0: begin
					b0 = preset_b0[p];
					a1 = preset_a1[p];
					a2 = preset_a2[p];
				end
				1: begin
					b0 = preset_b0[p] ^ $urandom_range(255);
					a1 = preset_a1[p] ^ $urandom_range(255);
					a2 = preset_a2[p] ^ $urandom_range(255);
				end
				2: begin
					b0 = $urandom();
					a1 = $urandom();
					a2 = $urandom();
				end
				default: begin
					b0 = corner_coef[$urandom_range(4)];
					a1 = corner_coef[$urandom_range(4)];
					a2 = corner_coef[$urandom_range(4)];
				end
			endcase
			program_filter(en_word, b0, a1, a2);
			calm <= (ph == 3);
			repeat (PHASE_LEN) queue_sample(next_sample());
			settle();
		end
		calm <= 1'b0;

		repeat (SETTLE) @(posedge clk);
		if (filtered_q.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("biquad_lowpass_filter regression: pass");
		end else begin
			$display("biquad_lowpass_filter regression: fail");
		end
		$finish;
	end

endmodule
